/* sv/gossip_membership_table_macros.svh */
// Assertion macros used by the gossip membership table datapath.
`ifndef GOSSIP_MEMBERSHIP_TABLE_MACROS_SVH
`define GOSSIP_MEMBERSHIP_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GMT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/gmt_pkg.sv */
// Types and codes shared by the gossip membership table modules.
package gmt_pkg;

  // input actions
  localparam logic [1:0] ACT_JOIN   = 2'd0;
  localparam logic [1:0] ACT_GOSSIP = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_TARGET = 2'd1;
  localparam logic [1:0] KIND_IDLE   = 2'd2;

  // join / gossip status codes
  localparam logic [1:0] ST_UPDATED  = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_IGNORED  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] CFG_OWN_ID   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_START_IG = 2'd2;

  // reset values of the configuration registers
  localparam logic [31:0] OWN_ID_RST  = 32'd1;
  localparam logic [15:0] TIMEOUT_RST = 16'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] member_id;
    logic [15:0] member_port;
    logic [31:0] member_heartbeat;
    logic [31:0] current_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] target_id;
    logic [15:0] target_port;
    logic [31:0] target_heartbeat;
    logic        last;
  } out_item_t;

  // one table row
  typedef struct packed {
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
    logic [31:0] tm;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture the input item
    logic grp_start;   // begin join / gossip lookup
    logic tick_start;  // bump own heartbeat, begin compaction
    logic tick_idle;   // result is a tick with no target
    logic search;      // lookup pass active
    logic compact;     // compaction pass active
    logic emit_rd;     // fetch next row for target emission
    logic emit_out;    // send fetched row as a target
    logic res_out;     // send the single result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic       in_group;
    logic       search_done;
    logic       compact_done;
    logic       no_targets;
    logic       is_self;
    logic       out_free;
    logic       last_tgt;
  } stat_t;

endpackage

/* sv/gmt_ctrl.sv */
// Sequencing state machine of the gossip membership table.
module gmt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  gmt_pkg::stat_t st,
  output gmt_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_SEARCH   = 3'd2;
  localparam logic [2:0] S_COMPACT  = 3'd3;
  localparam logic [2:0] S_EMIT_RD  = 3'd4;
  localparam logic [2:0] S_EMIT_CHK = 3'd5;
  localparam logic [2:0] S_RESULT   = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st.action) inside
          gmt_pkg::ACT_JOIN, gmt_pkg::ACT_GOSSIP: begin
            cmd.grp_start = 1'b1;
            state_nxt     = S_SEARCH;
          end
          gmt_pkg::ACT_TICK: begin
            if (st.in_group) begin
              cmd.tick_start = 1'b1;
              state_nxt      = S_COMPACT;
            end else begin
              cmd.tick_idle = 1'b1;
              state_nxt     = S_RESULT;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (st.search_done) state_nxt = S_RESULT;
      end
      S_COMPACT: begin
        cmd.compact = 1'b1;
        if (st.compact_done) begin
          if (st.no_targets) begin
            cmd.tick_idle = 1'b1;
            state_nxt     = S_RESULT;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EMIT_CHK;
      end
      S_EMIT_CHK: begin
        if (st.is_self) begin
          state_nxt = S_EMIT_RD;
        end else if (st.out_free) begin
          cmd.emit_out = 1'b1;
          state_nxt    = st.last_tgt ? S_IDLE : S_EMIT_RD;
        end
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.res_out = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/gmt_dp.sv */
// Table memory, counters, configuration and output register of the membership table.
`include "gossip_membership_table_macros.svh"

module gmt_dp #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  gmt_pkg::in_item_t                in_item,
  input  logic                             cfg_we,
  input  logic [gmt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [gmt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  gmt_pkg::cmd_t                    cmd,
  output gmt_pkg::stat_t                   st,
  output logic                             out_valid,
  output gmt_pkg::out_item_t               out_item,
  input  logic                             out_stall
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  gmt_pkg::entry_t mem [TABLE_DEPTH];

  gmt_pkg::in_item_t  item_r;
  logic [31:0]        own_id_r, own_id_nxt;
  logic [15:0]        timeout_r, timeout_nxt;
  logic               in_group_r, in_group_nxt;
  logic [31:0]        own_hb_r, own_hb_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]   cur_idx_r;
  logic [CNT_W-1:0]   kept_r, kept_nxt;
  logic [CNT_W-1:0]   tgt_r, tgt_nxt;
  logic               rd_vld_r;
  gmt_pkg::entry_t    rd_data_r;
  logic [1:0]         res_kind_r, res_kind_nxt;
  logic [1:0]         res_stat_r, res_stat_nxt;
  logic               out_valid_r, out_valid_nxt;
  gmt_pkg::out_item_t out_r, out_nxt;

  logic               rd_avail, hit, search_done, compact_done, is_self, keep, out_free;
  logic               commit, rd_en, mem_we;
  logic [IDX_W-1:0]   rd_addr, mem_waddr;
  gmt_pkg::entry_t    mem_wdata;
  logic [32:0]        lag;
  logic [1:0]         commit_stat;
  logic               append;

  // pass bookkeeping
  assign rd_avail     = (rd_idx_r != count_r);
  assign hit          = rd_vld_r && (rd_data_r.id == item_r.member_id);
  assign search_done  = hit || (!rd_vld_r && !rd_avail);
  assign compact_done = !rd_vld_r && !rd_avail;
  assign is_self      = (rd_data_r.id == own_id_r);
  assign out_free     = !out_valid_r || !out_stall;
  assign commit       = cmd.search && search_done;
  assign rd_en        = (cmd.search && rd_avail && !hit) || (cmd.compact && rd_avail) ||
                        cmd.emit_rd;
  assign rd_addr      = rd_idx_r[IDX_W-1:0];

  // staleness: exact signed lag against twice the timeout
  assign lag  = {1'b0, own_hb_r} - {1'b0, rd_data_r.hb};
  assign keep = lag[32] || (lag[31:0] < {15'd0, timeout_r, 1'b0});

  // table write: update on hit, append on a miss unless full or a zero-id gossip, move during compaction
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = cur_idx_r[IDX_W-1:0];
    mem_wdata   = rd_data_r;
    commit_stat = gmt_pkg::ST_UPDATED;
    append      = 1'b0;
    if (commit) begin
      if (hit) begin
        if (item_r.action == gmt_pkg::ACT_JOIN) begin
          mem_we         = 1'b1;
          mem_wdata.port = item_r.member_port;
          mem_wdata.tm   = item_r.current_time;
          if (item_r.member_heartbeat > rd_data_r.hb) mem_wdata.hb = item_r.member_heartbeat;
        end else if (item_r.member_heartbeat >= rd_data_r.hb) begin
          mem_we       = 1'b1;
          mem_wdata.hb = item_r.member_heartbeat;
          mem_wdata.tm = item_r.current_time;
        end
      end else if (item_r.action == gmt_pkg::ACT_GOSSIP && item_r.member_id == 32'd0) begin
        commit_stat = gmt_pkg::ST_IGNORED;
      end else if (count_r != DEPTH_C) begin
        append      = 1'b1;
        mem_we      = 1'b1;
        mem_waddr   = count_r[IDX_W-1:0];
        mem_wdata   = '{id: item_r.member_id, port: item_r.member_port,
                        hb: item_r.member_heartbeat, tm: item_r.current_time};
        commit_stat = gmt_pkg::ST_INSERTED;
      end else begin
        commit_stat = gmt_pkg::ST_FULL;
      end
    end else if (cmd.compact && rd_vld_r && keep) begin
      mem_we    = 1'b1;
      mem_waddr = kept_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // counters, configuration and group state
  always_comb begin
    own_id_nxt   = own_id_r;
    timeout_nxt  = timeout_r;
    in_group_nxt = in_group_r;
    own_hb_nxt   = own_hb_r;
    count_nxt    = count_r;
    rd_idx_nxt   = rd_idx_r;
    kept_nxt     = kept_r;
    tgt_nxt      = tgt_r;
    res_kind_nxt = res_kind_r;
    res_stat_nxt = res_stat_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        gmt_pkg::CFG_OWN_ID:   own_id_nxt   = cfg_wdata;
        gmt_pkg::CFG_TIMEOUT:  timeout_nxt  = cfg_wdata[15:0];
        gmt_pkg::CFG_START_IG: in_group_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
    if (cmd.grp_start) begin
      in_group_nxt = 1'b1;
      rd_idx_nxt   = '0;
    end
    if (cmd.tick_start) begin
      own_hb_nxt = own_hb_r + 32'd1;
      rd_idx_nxt = '0;
      kept_nxt   = '0;
      tgt_nxt    = '0;
    end
    if (rd_en) rd_idx_nxt = rd_idx_r + ONE_C;
    if (commit) begin
      res_kind_nxt = gmt_pkg::KIND_STATUS;
      res_stat_nxt = commit_stat;
      if (append) count_nxt = count_r + ONE_C;
    end
    if (cmd.compact && rd_vld_r && keep) begin
      kept_nxt = kept_r + ONE_C;
      if (!is_self) tgt_nxt = tgt_r + ONE_C;
    end
    if (cmd.compact && compact_done) begin
      count_nxt  = kept_r;
      rd_idx_nxt = '0;
    end
    if (cmd.tick_idle) begin
      res_kind_nxt = gmt_pkg::KIND_IDLE;
      res_stat_nxt = gmt_pkg::ST_UPDATED;
    end
    if (cmd.emit_out) tgt_nxt = tgt_r - ONE_C;
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (cmd.emit_out) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '{kind: gmt_pkg::KIND_TARGET, status: gmt_pkg::ST_UPDATED,
                        target_id: rd_data_r.id, target_port: rd_data_r.port,
                        target_heartbeat: rd_data_r.hb, last: (tgt_r == ONE_C)};
    end else if (cmd.res_out) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '{kind: res_kind_r, status: res_stat_r, target_id: 32'd0,
                        target_port: 16'd0, target_heartbeat: 32'd0, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r    <= gmt_pkg::OWN_ID_RST;
      timeout_r   <= gmt_pkg::TIMEOUT_RST;
      in_group_r  <= 1'b0;
      own_hb_r    <= '0;
      count_r     <= '0;
      rd_idx_r    <= '0;
      kept_r      <= '0;
      tgt_r       <= '0;
      rd_vld_r    <= 1'b0;
      res_kind_r  <= gmt_pkg::KIND_STATUS;
      res_stat_r  <= gmt_pkg::ST_UPDATED;
      out_valid_r <= 1'b0;
    end else begin
      own_id_r    <= own_id_nxt;
      timeout_r   <= timeout_nxt;
      in_group_r  <= in_group_nxt;
      own_hb_r    <= own_hb_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      kept_r      <= kept_nxt;
      tgt_r       <= tgt_nxt;
      rd_vld_r    <= rd_en;
      res_kind_r  <= res_kind_nxt;
      res_stat_r  <= res_stat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (rd_en) cur_idx_r <= rd_idx_r;
    out_r <= out_nxt;
  end

  assign st = '{action: item_r.action, in_group: in_group_r, search_done: search_done,
                compact_done: compact_done, no_targets: (tgt_r == '0), is_self: is_self,
                out_free: out_free, last_tgt: (tgt_r == ONE_C)};

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `GMT_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= DEPTH_C, "entry count above table depth")
  `GMT_ASSERT_IMPL(a_no_rw_clash, mem_we && rd_en, mem_waddr != rd_addr, "table rw same row")
  `GMT_ASSERT_IMPL(a_kept_behind, cmd.compact, kept_r <= rd_idx_r, "compaction write ahead")
  `GMT_ASSERT_IMPL(a_emit_pending, cmd.emit_out, tgt_r != '0, "target sent with none left")
  `GMT_ASSERT_NEXT(a_out_loaded, cmd.res_out || cmd.emit_out, out_valid_r, "result not held")

endmodule

/* sv/gossip_membership_table.sv */
// Top level of the gossip heartbeat membership table.
//
// Input channel (in_valid / in_stall / in_item): one transfer per item; action is a
// join request, a gossiped list entry or a periodic tick. Only one item is in work at
// a time; in_stall is high from the transfer until its last result has been queued.
// Result channel (out_valid / out_stall / out_item): a single output register; the
// final result of an item carries last. A join or gossip gives one status result
// after a lookup that reads the table one row per cycle and stops early on a
// match. A tick in group first compacts the table, then fetches each remaining
// row in turn and sends one target per row that is not this node; a tick out of
// group or with no target gives one result.
// While the receiver stalls, the pending result holds and the block waits.
// Configuration (cfg_we / cfg_addr / cfg_wdata) is written while idle; writing the
// start flag also loads the in-group state. Synchronous reset empties the table,
// clears own heartbeat and in-group state and restores register defaults.
module gossip_membership_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  gmt_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output gmt_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [gmt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [gmt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  gmt_pkg::cmd_t  cmd;
  gmt_pkg::stat_t st;

  gmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  gmt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

endmodule

/* bench/testbench.sv */
// Self-checking bench for the gossip membership table against a table model.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned ROWS = 16;
  localparam logic [1:0] ACT_NONE = 2'd3;      // spare action code, the block drops it
  localparam logic [1:0] ST_BLANK = 2'd0;      // status field of target and idle results
  localparam int unsigned SETTLE_CYCLES = 3 * ROWS + 16;
  localparam int unsigned PRINT_MAX = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  gmt_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gmt_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [gmt_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [gmt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // membership table model and its register copies
  gmt_pkg::entry_t rows_m [ROWS];
  int unsigned row_count = 0;
  logic [31:0] beat_m = '0;
  logic member_m = 1'b0;
  logic [31:0] self_id_m = gmt_pkg::OWN_ID_RST;
  logic [15:0] timeout_m = gmt_pkg::TIMEOUT_RST;

  gmt_pkg::in_item_t msgs_to_send [$];
  gmt_pkg::out_item_t replies_due [$];
  gmt_pkg::out_item_t want_reply;
  int unsigned mismatch_count = 0;
  bit steady = 1'b0;   // no idling on either side while set

  gossip_membership_table #(.TABLE_DEPTH(ROWS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void push_reply(input logic [1:0] kind, input logic [1:0] status,
                                     input gmt_pkg::entry_t row, input logic last);
    gmt_pkg::out_item_t r;
    r.kind = kind;
    r.status = status;
    r.target_id = row.id;
    r.target_port = row.port;
    r.target_heartbeat = row.hb;
    r.last = last;
    replies_due = {replies_due, r};
  endfunction

  // Append one item to the sender's queue.
  function automatic void queue_msg(input gmt_pkg::in_item_t m);
    msgs_to_send = {msgs_to_send, m};
  endfunction

  function automatic int find_row(input logic [31:0] id);
    for (int i = 0; i < row_count; i++)
      if (rows_m[i].id == id) return i;
    return -1;
  endfunction

  function automatic logic [1:0] append_row(input gmt_pkg::in_item_t m);
    if (row_count >= ROWS) return gmt_pkg::ST_FULL;
    rows_m[row_count] = {m.member_id, m.member_port, m.member_heartbeat, m.current_time};
    row_count++;
    return gmt_pkg::ST_INSERTED;
  endfunction

  // Update the table model with one accepted item and queue the results it owes.
  function automatic void apply_membership_item(input gmt_pkg::in_item_t m);
    int idx;
    int unsigned kept;
    int unsigned n_tgt;
    int unsigned sent;
    longint lag;
    logic [1:0] st;
    case (m.action)
      gmt_pkg::ACT_JOIN: begin
        member_m = 1'b1;
        idx = find_row(m.member_id);
        if (idx >= 0) begin
          if (m.member_heartbeat > rows_m[idx].hb) rows_m[idx].hb = m.member_heartbeat;
          rows_m[idx].port = m.member_port;
          rows_m[idx].tm = m.current_time;
          st = gmt_pkg::ST_UPDATED;
        end else begin
          st = append_row(m);
        end
        push_reply(gmt_pkg::KIND_STATUS, st, '0, 1'b1);
      end
      gmt_pkg::ACT_GOSSIP: begin
        member_m = 1'b1;
        idx = find_row(m.member_id);
        if (idx >= 0) begin
          // a stale heartbeat leaves the row alone
          if (m.member_heartbeat >= rows_m[idx].hb) begin
            rows_m[idx].hb = m.member_heartbeat;
            rows_m[idx].tm = m.current_time;
          end
          st = gmt_pkg::ST_UPDATED;
        end else if (m.member_id == '0) begin
          st = gmt_pkg::ST_IGNORED;
        end else begin
          st = append_row(m);
        end
        push_reply(gmt_pkg::KIND_STATUS, st, '0, 1'b1);
      end
      gmt_pkg::ACT_TICK: begin
        if (!member_m) begin
          push_reply(gmt_pkg::KIND_IDLE, ST_BLANK, '0, 1'b1);
        end else begin
          beat_m++;
          // drop rows lagging by twice the timeout, keep order
          kept = 0;
          for (int i = 0; i < row_count; i++) begin
            lag = longint'(beat_m) - longint'(rows_m[i].hb);
            if (lag < 2 * longint'(timeout_m)) begin
              rows_m[kept] = rows_m[i];
              kept++;
            end
          end
          row_count = kept;
          n_tgt = 0;
          for (int i = 0; i < row_count; i++)
            if (rows_m[i].id != self_id_m) n_tgt++;
          sent = 0;
          for (int i = 0; i < row_count; i++) begin
            if (rows_m[i].id != self_id_m) begin
              sent++;
              push_reply(gmt_pkg::KIND_TARGET, ST_BLANK, rows_m[i], sent == n_tgt);
            end
          end
          if (n_tgt == 0) push_reply(gmt_pkg::KIND_IDLE, ST_BLANK, '0, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic gmt_pkg::in_item_t msg(input logic [1:0] act, input logic [31:0] id,
                                            input logic [15:0] port, input logic [31:0] hb,
                                            input logic [31:0] now);
    gmt_pkg::in_item_t m;
    m.action = act;
    m.member_id = id;
    m.member_port = port;
    m.member_heartbeat = hb;
    m.current_time = now;
    return m;
  endfunction

  // Random item; heartbeats mostly sit close to the expected own heartbeat.
  function automatic gmt_pkg::in_item_t random_msg(input logic [31:0] base);
    gmt_pkg::in_item_t m;
    int unsigned pick;
    logic [31:0] hb;
    logic [31:0] dec;
    pick = $urandom_range(99);
    if (pick < 30) m.action = gmt_pkg::ACT_JOIN;
    else if (pick < 70) m.action = gmt_pkg::ACT_GOSSIP;
    else if (pick < 95) m.action = gmt_pkg::ACT_TICK;
    else m.action = ACT_NONE;
    pick = $urandom_range(99);
    if (pick < 70) m.member_id = $urandom_range(22, 1);
    else if (pick < 78) m.member_id = self_id_m;
    else if (pick < 85) m.member_id = '0;
    else m.member_id = $urandom;
    pick = $urandom_range(99);
    if (pick < 80) begin
      hb = base + $urandom_range(6);
      dec = $urandom_range(14);
      m.member_heartbeat = (hb > dec) ? hb - dec : '0;
    end else if (pick < 98) begin
      m.member_heartbeat = $urandom_range(40);
    end else begin
      m.member_heartbeat = $urandom;
    end
    m.member_port = 16'($urandom_range(16'hFFFF));
    m.current_time = $urandom;
    return m;
  endfunction

  task automatic queue_random(input int unsigned n);
    logic [31:0] base;
    gmt_pkg::in_item_t m;
    int unsigned made;
    base = beat_m;
    made = 0;
    while (made < n) begin
      m = random_msg(base);
      queue_msg(m);
      if (m.action != ACT_NONE) made++;
      if (m.action == gmt_pkg::ACT_TICK) base++;
    end
  endtask

  // Wait for the sender to run dry and every result to come back, then let the block settle.
  task automatic wait_quiet();
    while (msgs_to_send.size() != 0 || in_valid || replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [gmt_pkg::CFG_ADDR_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      gmt_pkg::CFG_OWN_ID:   self_id_m = val;
      gmt_pkg::CFG_TIMEOUT:  timeout_m = val[15:0];
      gmt_pkg::CFG_START_IG: member_m = val[0];
      default: ;
    endcase
  endtask

  function automatic void flag_field(input string field, input logic [31:0] want,
                                     input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= PRINT_MAX)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  // Driver: offer the next item, hold it while stalled, predict on each transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_membership_item(in_item);
      if (!in_valid || !in_stall) begin
        if (msgs_to_send.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
          in_valid <= 1'b1;
          in_item <= msgs_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest owed result.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_MAX)
            $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
        end else begin
          want_reply = replies_due.pop_front();
          flag_field("kind", 32'(want_reply.kind), 32'(out_item.kind));
          flag_field("status", 32'(want_reply.status), 32'(out_item.status));
          flag_field("target_id", want_reply.target_id, out_item.target_id);
          flag_field("target_port", 32'(want_reply.target_port),
                     32'(out_item.target_port));
          flag_field("target_heartbeat", want_reply.target_heartbeat,
                     out_item.target_heartbeat);
          flag_field("last", 32'(want_reply.last), 32'(out_item.last));
        end
      end
      out_stall <= !steady && ($urandom_range(99) < 33);
    end
  end

  // Stimulus phases; registers change only once the block is quiet.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // default registers, not in group yet
    queue_msg(msg(gmt_pkg::ACT_TICK, '0, '0, '0, '0));            // out of group
    queue_msg(msg(ACT_NONE, '1, '1, '1, '1));                     // dropped, no result
    queue_msg(msg(gmt_pkg::ACT_GOSSIP, '0, 16'h1234, 3, $urandom)); // zero id, joins group
    queue_msg(msg(gmt_pkg::ACT_TICK, '0, '0, '0, $urandom));      // empty table
    queue_msg(msg(gmt_pkg::ACT_JOIN, '0, '0, 2, $urandom));       // zero id stored on join
    queue_msg(msg(gmt_pkg::ACT_JOIN, '0, '1, 1, $urandom));       // lower hb kept, port moves
    queue_msg(msg(gmt_pkg::ACT_GOSSIP, 7, 16'h0007, 6, $urandom));
    queue_msg(msg(gmt_pkg::ACT_GOSSIP, 7, 16'h0008, 3, $urandom)); // stale gossip
    queue_msg(msg(gmt_pkg::ACT_GOSSIP, 7, 16'h0009, 6, $urandom)); // equal hb refreshes
    queue_msg(msg(gmt_pkg::ACT_JOIN, gmt_pkg::OWN_ID_RST, 16'h0100, 0, $urandom)); // self row
    queue_msg(msg(gmt_pkg::ACT_JOIN, '1, '1, '1, '1));            // far ahead, never aged out
    queue_msg(msg(gmt_pkg::ACT_TICK, '0, '0, '0, $urandom));
    for (int i = 0; i < 12; i++)
      queue_msg(msg(gmt_pkg::ACT_JOIN, 20 + i, 16'($urandom_range(16'hFFFF)), 1, $urandom));
    queue_msg(msg(gmt_pkg::ACT_JOIN, 40, 16'h0040, 2, $urandom));   // table full
    queue_msg(msg(gmt_pkg::ACT_GOSSIP, 41, 16'h0041, 2, $urandom)); // table full
    queue_msg(msg(gmt_pkg::ACT_TICK, '0, '0, '0, $urandom));      // fifteen targets
    queue_random(60);
    wait_quiet();

    // max own id, timeout of one, start as introducer
    set_reg(gmt_pkg::CFG_OWN_ID, '1);
    set_reg(gmt_pkg::CFG_TIMEOUT, 32'd1);
    set_reg(gmt_pkg::CFG_START_IG, 32'd1);
    queue_random(80);
    wait_quiet();

    // zero own id, widest timeout, no idling for this stretch
    steady = 1'b1;
    set_reg(gmt_pkg::CFG_OWN_ID, '0);
    set_reg(gmt_pkg::CFG_TIMEOUT, 32'hFFFF);
    set_reg(gmt_pkg::CFG_START_IG, 32'd0);
    queue_random(80);
    wait_quiet();
    steady = 1'b0;

    // zero timeout: every row not ahead goes on the first tick
    set_reg(gmt_pkg::CFG_OWN_ID, $urandom);
    set_reg(gmt_pkg::CFG_TIMEOUT, 32'd0);
    set_reg(gmt_pkg::CFG_START_IG, 32'd1);
    queue_msg(msg(gmt_pkg::ACT_TICK, '0, '0, '0, $urandom));
    queue_random(40);
    wait_quiet();

    set_reg(gmt_pkg::CFG_OWN_ID, 32'd5);
    set_reg(gmt_pkg::CFG_TIMEOUT, 32'd3);
    set_reg(gmt_pkg::CFG_START_IG, 32'd0);
    queue_random(90);
    wait_quiet();

    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
